@@ design/quadrant_pattern_sad_matcher_defines.svh @@
// ----------------------------------------------------------------------------
// Quadrant pattern SAD matcher assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef QUADRANT_PATTERN_SAD_MATCHER_DEFINES_SVH
`define QUADRANT_PATTERN_SAD_MATCHER_DEFINES_SVH

`ifndef SYNTH
`define QPSM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define QPSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define QPSM_ASSERT(label, clk, rst, prop, msg)
`define QPSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ design/qpsm_pkg.sv @@
// ----------------------------------------------------------------------------
// Quadrant pattern SAD matcher package
// Widths, the coverage pattern level table and pipeline control types.
// ----------------------------------------------------------------------------
package qpsm_pkg;

  localparam int SAMPLE_W          = 9;
  localparam int ERR_W             = 11;
  localparam int IDX_W             = 5;
  localparam int CORNERS           = 4;
  localparam int TABLE_SIZE        = 20;
  localparam int PATTERN_COUNT_DEF = 20;
  localparam int GROUP_SIZE        = 4;
  localparam int LEVEL_FULL        = 256;
  localparam int ERR_MAX           = 1024;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [ERR_W-1:0]    err_t;
  typedef logic [IDX_W-1:0]    idx_t;

  typedef struct packed {
    logic lane_en;
    logic group_en;
    logic out_en;
  } pipe_ctrl_t;

  // Corner order: top left, top right, bottom left, bottom right.
  localparam sample_t LEVEL_TABLE [TABLE_SIZE][CORNERS] = '{
    '{9'd0,   9'd0,   9'd0,   9'd0},
    '{9'd64,  9'd64,  9'd64,  9'd64},
    '{9'd128, 9'd128, 9'd128, 9'd128},
    '{9'd192, 9'd192, 9'd192, 9'd192},
    '{9'd256, 9'd0,   9'd0,   9'd0},
    '{9'd0,   9'd256, 9'd0,   9'd0},
    '{9'd256, 9'd256, 9'd0,   9'd0},
    '{9'd0,   9'd0,   9'd256, 9'd0},
    '{9'd256, 9'd0,   9'd256, 9'd0},
    '{9'd0,   9'd256, 9'd256, 9'd0},
    '{9'd256, 9'd256, 9'd256, 9'd0},
    '{9'd0,   9'd0,   9'd0,   9'd256},
    '{9'd256, 9'd0,   9'd0,   9'd256},
    '{9'd0,   9'd256, 9'd0,   9'd256},
    '{9'd256, 9'd256, 9'd0,   9'd256},
    '{9'd0,   9'd0,   9'd256, 9'd256},
    '{9'd256, 9'd0,   9'd256, 9'd256},
    '{9'd0,   9'd256, 9'd256, 9'd256},
    '{9'd256, 9'd256, 9'd256, 9'd256},
    '{9'd26,  9'd26,  9'd26,  9'd26}
  };

  function automatic sample_t clamp_sample(input sample_t v);
    return (v > sample_t'(LEVEL_FULL)) ? sample_t'(LEVEL_FULL) : v;
  endfunction

endpackage

@@ design/qpsm_lane.sv @@
// ----------------------------------------------------------------------------
// Quadrant pattern SAD lane
// Sum of absolute differences between the cell and one fixed pattern.
// ----------------------------------------------------------------------------
module qpsm_lane import qpsm_pkg::*; #(
  parameter int LANE = 0
) (
  input  logic    clk,
  input  logic    en,
  input  sample_t samples [CORNERS],
  output err_t    err
);

  sample_t diff [CORNERS];
  err_t    err_next;

  always_comb begin
    for (int c = 0; c < CORNERS; c++) begin
      if (samples[c] > LEVEL_TABLE[LANE][c]) begin
        diff[c] = samples[c] - LEVEL_TABLE[LANE][c];
      end else begin
        diff[c] = LEVEL_TABLE[LANE][c] - samples[c];
      end
    end
    err_next = (ERR_W'(diff[0]) + ERR_W'(diff[1])) + (ERR_W'(diff[2]) + ERR_W'(diff[3]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err <= err_next;
    end
  end

endmodule

@@ design/qpsm_merge.sv @@
// ----------------------------------------------------------------------------
// Quadrant pattern SAD merge tree
// Two registered levels of minimum search; the lower index wins on a tie.
// ----------------------------------------------------------------------------
module qpsm_merge import qpsm_pkg::*; #(
  parameter int LANES = PATTERN_COUNT_DEF
) (
  input  logic       clk,
  input  pipe_ctrl_t ctrl,
  input  err_t       errs [LANES],
  output idx_t       best_idx,
  output err_t       best_err
);

  localparam int GROUPS = (LANES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PADDED = GROUPS * GROUP_SIZE;

  err_t pad_err [PADDED];
  err_t grp_err_next [GROUPS];
  idx_t grp_idx_next [GROUPS];
  err_t grp_err [GROUPS];
  idx_t grp_idx [GROUPS];
  err_t fin_err_next;
  idx_t fin_idx_next;

  // Unused slots hold the largest code, which no real sum reaches.
  for (genvar j = 0; j < PADDED; j++) begin : g_pad
    if (j < LANES) begin : g_real
      assign pad_err[j] = errs[j];
    end else begin : g_fill
      assign pad_err[j] = '1;
    end
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_err_next[g] = pad_err[g*GROUP_SIZE];
      grp_idx_next[g] = IDX_W'(g*GROUP_SIZE);
      for (int k = 1; k < GROUP_SIZE; k++) begin
        if (pad_err[g*GROUP_SIZE+k] < grp_err_next[g]) begin
          grp_err_next[g] = pad_err[g*GROUP_SIZE+k];
          grp_idx_next[g] = IDX_W'(g*GROUP_SIZE+k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.group_en) begin
      grp_err <= grp_err_next;
      grp_idx <= grp_idx_next;
    end
  end

  always_comb begin
    fin_err_next = grp_err[0];
    fin_idx_next = grp_idx[0];
    for (int g = 1; g < GROUPS; g++) begin
      if (grp_err[g] < fin_err_next) begin
        fin_err_next = grp_err[g];
        fin_idx_next = grp_idx[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_en) begin
      best_err <= fin_err_next;
      best_idx <= fin_idx_next;
    end
  end

endmodule

@@ design/quadrant_pattern_sad_matcher.sv @@
// ----------------------------------------------------------------------------
// Quadrant pattern SAD matcher
// Finds the coverage pattern closest to a 2x2 luminance cell.
// ----------------------------------------------------------------------------
// One transfer on the slave channel carries the four samples of a cell; each
// sample above full brightness is saturated to it. One transfer on the master
// channel returns the index of the best pattern and its sum of absolute
// differences, in input order.
// The pipeline has four register stages: the sample register, one SAD lane
// per pattern, a group minimum level and the output register. One transfer
// per cycle is sustained in both directions while the receiver does not
// stall.
// Each stage holds its item until the next stage can take it, so while the
// receiver stalls the block keeps accepting input until every stage is full,
// then drops s_axis_tready. No result is lost or repeated.
// Reset empties all stages; no payload is cleared.
// ----------------------------------------------------------------------------
`include "quadrant_pattern_sad_matcher_defines.svh"

module quadrant_pattern_sad_matcher import qpsm_pkg::*; #(
  parameter int PATTERN_COUNT = PATTERN_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [8:0] sample_top_left, [17:9] sample_top_right,
  // [26:18] sample_bottom_left, [35:27] sample_bottom_right, [39:36] zero
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] pattern_index, [15:5] match_error
  output logic [15:0] m_axis_tdata
);

  localparam int LANES = (PATTERN_COUNT < 1) ? 1 :
                         (PATTERN_COUNT > TABLE_SIZE) ? TABLE_SIZE : PATTERN_COUNT;

  logic       v_in;
  logic       v_lane;
  logic       v_grp;
  logic       v_out;
  logic       rdy_in;
  logic       rdy_lane;
  logic       rdy_grp;
  logic       rdy_out;
  pipe_ctrl_t ctrl;
  sample_t    samples [CORNERS];
  err_t       lane_err [LANES];
  idx_t       best_idx;
  err_t       best_err;

  assign rdy_out  = !v_out || m_axis_tready;
  assign rdy_grp  = !v_grp || rdy_out;
  assign rdy_lane = !v_lane || rdy_grp;
  assign rdy_in   = !v_in || rdy_lane;

  assign ctrl.lane_en  = rdy_lane;
  assign ctrl.group_en = rdy_grp;
  assign ctrl.out_en   = rdy_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_in   <= 1'b0;
      v_lane <= 1'b0;
      v_grp  <= 1'b0;
      v_out  <= 1'b0;
    end else begin
      if (rdy_in) begin
        v_in <= s_axis_tvalid;
      end
      if (rdy_lane) begin
        v_lane <= v_in;
      end
      if (rdy_grp) begin
        v_grp <= v_lane;
      end
      if (rdy_out) begin
        v_out <= v_grp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_in) begin
      for (int c = 0; c < CORNERS; c++) begin
        samples[c] <= clamp_sample(s_axis_tdata[c*SAMPLE_W +: SAMPLE_W]);
      end
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    qpsm_lane #(
      .LANE (i)
    ) u_lane (
      .clk     (clk),
      .en      (ctrl.lane_en),
      .samples (samples),
      .err     (lane_err[i])
    );
  end

  qpsm_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk      (clk),
    .ctrl     (ctrl),
    .errs     (lane_err),
    .best_idx (best_idx),
    .best_err (best_err)
  );

  assign s_axis_tready = rdy_in;
  assign m_axis_tvalid = v_out;
  assign m_axis_tdata  = {best_err, best_idx};

  `QPSM_ASSERT(a_result_range, clk, rst, m_axis_tvalid |-> (best_idx < idx_t'(LANES)) && (best_err <= err_t'(ERR_MAX)), "result outside the pattern table or error range")
  `QPSM_ASSERT(a_full_blocks_input, clk, rst, (v_in && v_lane && v_grp && v_out && !m_axis_tready) |-> !s_axis_tready, "input taken while every stage is full")
  `QPSM_ASSERT_NEXT(a_stall_holds_result, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule
